// ----- hdl/eas_pkg.sv -----
// encoder average speed: shared types and constants
// depends on nothing; used by the channel interfaces and all modules
`default_nettype none

package eas_pkg;

  localparam int AngleWidth      = 14;  // width of the angle field
  localparam int SumWidth        = 16;  // tick sum and interval count
  localparam int SpeedWidth      = 17;  // signed quotient incl. +32768
  localparam int DefaultAngleBits = 14;

  typedef enum logic [0:0] {
    OpSample = 1'b0,
    OpRead   = 1'b1
  } op_e;

  typedef logic signed [SumWidth-1:0]   sum_t;
  typedef logic signed [SpeedWidth-1:0] speed_t;

  // request to the serial divider and its answer
  typedef struct packed {
    logic start;
    sum_t dividend;
    sum_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    speed_t quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/eas_if.sv -----
// encoder average speed: valid/ready channel interfaces for sample and result requests
// depends on eas_pkg
`default_nettype none

interface eas_in_if;
  import eas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [0:0]            opcode;
  logic [AngleWidth-1:0] angle;

  modport source (output valid, output opcode, output angle, input ready);
  modport sink   (input valid, input opcode, input angle, output ready);
endinterface

interface eas_out_if;
  import eas_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SpeedWidth-1:0] speed;
  logic                         zero_interval;

  modport source (output valid, output speed, output zero_interval, input ready);
  modport sink   (input valid, input speed, input zero_interval, output ready);
endinterface

`default_nettype wire

// ----- hdl/eas_divider.sv -----
// encoder average speed: serial signed divider, one restoring step per cycle
// depends on eas_pkg
`default_nettype none

module eas_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire eas_pkg::div_req_t req_i,
  output eas_pkg::div_rsp_t      rsp_o
);
  import eas_pkg::*;

  localparam int CntWidth = $clog2(SumWidth);

  typedef enum logic [1:0] {
    DvIdle,
    DvRun,
    DvDone
  } dv_state_e;

  dv_state_e             state_q;
  logic [CntWidth-1:0]   step_q;
  logic                  neg_q;
  logic [SumWidth-1:0]   quo_q;
  logic [SumWidth-1:0]   rem_q;
  logic [SumWidth-1:0]   dvs_q;
  logic                  done_q;
  speed_t                quotient_q;

  logic [SumWidth:0]     trial;
  logic [SumWidth+1:0]   diff;
  logic [SumWidth-1:0]   abs_dividend;
  logic [SumWidth-1:0]   abs_divisor;

  // magnitudes fit unsigned 16 bits, the most negative value included
  assign abs_dividend = req_i.dividend[SumWidth-1] ? SumWidth'(-req_i.dividend)
                                                   : req_i.dividend;
  assign abs_divisor  = req_i.divisor[SumWidth-1] ? SumWidth'(-req_i.divisor)
                                                  : req_i.divisor;

  assign trial = {rem_q, quo_q[SumWidth-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= DvIdle;
      step_q     <= '0;
      done_q     <= 1'b0;
      neg_q      <= 1'b0;
      quo_q      <= '0;
      rem_q      <= '0;
      dvs_q      <= '0;
      quotient_q <= '0;
    end else begin
      done_q <= (state_q == DvDone);
      unique case (state_q)
        DvIdle: begin
          if (req_i.start) begin
            neg_q   <= req_i.dividend[SumWidth-1] ^ req_i.divisor[SumWidth-1];
            quo_q   <= abs_dividend;
            dvs_q   <= abs_divisor;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= DvRun;
          end
        end
        DvRun: begin
          if (!diff[SumWidth+1]) begin
            rem_q <= diff[SumWidth-1:0];
            quo_q <= {quo_q[SumWidth-2:0], 1'b1};
          end else begin
            rem_q <= trial[SumWidth-1:0];
            quo_q <= {quo_q[SumWidth-2:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == CntWidth'(SumWidth - 1)) begin
            state_q <= DvDone;
          end
        end
        DvDone: begin
          quotient_q <= neg_q ? SpeedWidth'(-{1'b0, quo_q}) : SpeedWidth'({1'b0, quo_q});
          state_q    <= DvIdle;
        end
        default: state_q <= DvIdle;
      endcase
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quotient_q;

endmodule

`default_nettype wire

// ----- hdl/encoder_average_speed_core.sv -----
// encoder average speed: top level with tick accumulation, sequencing and result register
// depends on eas_pkg, eas_if.sv and eas_divider
`default_nettype none

// Average speed estimator for an absolute angle encoder. A sample request
// (opcode 0) takes the low ANGLE_BITS bits of the angle, forms the wrapped
// signed difference to the previous angle, adds it to a 16-bit wrapping tick
// sum and counts one interval; it gives no result and leaves the block ready.
// A read request (opcode 1) gives sum / count truncated toward zero as a
// 17-bit signed speed and clears both counters; with a zero count the speed
// is 0 and zero_interval is set. The quotient comes from a serial restoring
// divider that resolves one bit per cycle, so a read passes through 16 divide
// steps, sign fix, answer capture and output load before its result is valid,
// and the next request is taken from the cycle in which that result appears;
// a zero-count read skips the divide steps and the sign fix.
// The block takes no request while a division runs. The result sits in
// an output register, so new samples are taken while a result waits; a later
// read holds its answer until the output register is free.
module encoder_average_speed_core #(
  parameter int ANGLE_BITS = eas_pkg::DefaultAngleBits
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  eas_in_if.sink     sample_i,
  eas_out_if.source  result_o
);
  import eas_pkg::*;

  typedef enum logic [1:0] {
    StIdle,   // ready for requests
    StDiv,    // divider busy
    StHold    // answer ready, waiting for the output register
  } state_e;

  state_e                  state_q;
  logic [ANGLE_BITS-1:0]   prev_q;
  sum_t                    sum_q;
  sum_t                    count_q;
  speed_t                  res_speed_q;
  logic                    res_zero_q;
  logic                    out_valid_q;
  speed_t                  out_speed_q;
  logic                    out_zero_q;

  logic                    accept;
  logic                    is_read;
  logic                    out_free;
  logic                    out_load;
  logic [ANGLE_BITS-1:0]   angle_now;
  logic [ANGLE_BITS-1:0]   angle_diff;
  sum_t                    diff_ext;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign sample_i.ready = (state_q == StIdle);
  assign accept         = sample_i.valid && sample_i.ready;
  assign is_read        = (sample_i.opcode == OpRead);
  assign out_free       = !out_valid_q || result_o.ready;
  // answer moves into the output register
  assign out_load       = (state_q == StHold) && out_free;

  // wrapped difference, read as a signed ANGLE_BITS value and widened
  assign angle_now  = ANGLE_BITS'(sample_i.angle);
  assign angle_diff = angle_now - prev_q;
  assign diff_ext   = SumWidth'($signed(angle_diff));

  // divider gets the operands as they stand at the read request
  assign div_req.start    = accept && is_read && (count_q != '0);
  assign div_req.dividend = sum_q;
  assign div_req.divisor  = count_q;

  eas_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      res_speed_q <= '0;
      res_zero_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_speed_q <= '0;
      out_zero_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_speed_q <= res_speed_q;
        out_zero_q  <= res_zero_q;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (!is_read) begin
              // sample: accumulate ticks, count the interval
              sum_q   <= sum_q + diff_ext;
              count_q <= count_q + 1'b1;
              prev_q  <= angle_now;
            end else begin
              sum_q   <= '0;
              count_q <= '0;
              if (count_q == '0) begin
                res_speed_q <= '0;
                res_zero_q  <= 1'b1;
                state_q     <= StHold;
              end else begin
                res_zero_q <= 1'b0;
                state_q    <= StDiv;
              end
            end
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            res_speed_q <= div_rsp.quotient;
            state_q     <= StHold;
          end
        end
        StHold: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.speed         = out_speed_q;
  assign result_o.zero_interval = out_zero_q;

endmodule

`default_nettype wire
